>>> rtl/core/assert_macros.svh
// assertion macros shared by the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off during reset
`define EDTM_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never hold outside reset
`define EDTM_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

>>> rtl/core/edtm_pkg.sv
// types, constants and helpers of the echo distance trimmed mean filter
`timescale 1ns / 1ps
package edtm_pkg;

   localparam int CHANNELS      = 4;
   localparam int WINDOW        = 8;
   localparam int KEPT_COUNT    = 4;
   localparam int CENTER_OFFSET = 2;

   // kept entries and clamped start of the kept run in the sorted window
   localparam int KEPT      = (KEPT_COUNT < WINDOW) ? KEPT_COUNT : WINDOW;
   localparam int START_RAW = WINDOW / 2 - CENTER_OFFSET;
   localparam int START     = (START_RAW < 0) ? 0 :
                              ((START_RAW > WINDOW - KEPT) ? WINDOW - KEPT : START_RAW);

   localparam int CH_W   = 2;
   localparam int TICK_W = 16;
   localparam int OVF_W  = 8;
   localparam int CFG_W  = 16;
   localparam int DIST_W = 19;
   localparam int FRAC_W = 8;

   localparam int SUM_W  = TICK_W + $clog2(KEPT + 1);
   localparam int PROD_W = SUM_W + CFG_W;
   localparam int QUO_W  = PROD_W - FRAC_W;

   localparam int KEPT_LOG  = $clog2(KEPT);
   localparam bit KEPT_POW2 = ((1 << KEPT_LOG) == KEPT);
   localparam int REM_W     = KEPT_LOG + 1;

   localparam int DEPTH  = CHANNELS * WINDOW;
   localparam int ADDR_W = $clog2(DEPTH);

   localparam int CNT_TOP = (WINDOW > QUO_W) ? WINDOW : QUO_W;
   localparam int CNT_W   = $clog2(CNT_TOP + 1);
   localparam int PASS_W  = $clog2(WINDOW);

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   localparam logic [CFG_W-1:0] TPO_RESET = 16'd399;
   localparam logic [CFG_W-1:0] CM_RESET  = 16'd1114;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic {
      CSR_TPO = 1'b0,
      CSR_CM  = 1'b1
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICKS,
      ST_RAW,
      ST_LOAD,
      ST_SORT,
      ST_SUM,
      ST_MEAN,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_TICKS,
      OP_RAW,
      OP_LOAD,
      OP_CMP,
      OP_ROT,
      OP_SUM,
      OP_MEAN,
      OP_DIV
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [CNT_W-1:0] cnt;
   } ctrl_type;

   function automatic logic [DIST_W-1:0] sat_dist(input logic [QUO_W-1:0] q);
      logic [DIST_W-1:0] r;
      if (|q[QUO_W-1:DIST_W]) begin
         r = DIST_MAX;
      end else begin
         r = q[DIST_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/core/edtm_win_mem.sv
// per channel echo window memory with entry valid bits and window load sequencing
`timescale 1ns / 1ps
module edtm_win_mem (
   input  logic                         clock,
   input  logic                         reset,
   input  edtm_pkg::ctrl_type           ctrl,
   input  logic [edtm_pkg::CH_W-1:0]    channel,
   input  logic [edtm_pkg::TICK_W-1:0]  ticks,
   output logic                         shift_en,
   output logic [edtm_pkg::TICK_W-1:0]  shift_data
);
   import edtm_pkg::*;

   logic [TICK_W-1:0] win_mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DEPTH-1:0]  valid_in;
   logic [TICK_W-1:0] rd_data_ff;
   logic              rd_hit_ff;

   logic [ADDR_W-1:0] base;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic              wr_en;
   logic [TICK_W-1:0] rd_out;
   logic              load_op;

   always_comb begin
      load_op = (ctrl.op == OP_LOAD);
      base    = ADDR_W'(channel) * ADDR_W'(WINDOW);
      // read entry cnt+1, write it back one slot lower in the next cycle
      rd_en   = load_op && (ctrl.cnt < CNT_W'(WINDOW - 1));
      rd_addr = base + ADDR_W'(ctrl.cnt + CNT_W'(1));
      wr_en   = load_op && (ctrl.cnt != '0);
      wr_addr = base + ADDR_W'(ctrl.cnt - CNT_W'(1));
      rd_out  = rd_hit_ff ? rd_data_ff : '0;
      // newest echo goes into the last slot
      shift_data = (ctrl.cnt == CNT_W'(WINDOW)) ? ticks : rd_out;
      shift_en   = wr_en;
      valid_in   = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         win_mem_ff[wr_addr] <= shift_data;
      end
      if (rd_en) begin
         rd_data_ff <= win_mem_ff[rd_addr];
         rd_hit_ff  <= valid_ff[rd_addr];
      end
   end

endmodule

>>> rtl/core/edtm_sort_regs.sv
// rotating window registers with one shared compare-swap
`timescale 1ns / 1ps
module edtm_sort_regs (
   input  logic                         clock,
   input  edtm_pkg::ctrl_type           ctrl,
   input  logic                         shift_en,
   input  logic [edtm_pkg::TICK_W-1:0]  shift_data,
   output logic [edtm_pkg::TICK_W-1:0]  head
);
   import edtm_pkg::*;

   logic [TICK_W-1:0] r_ff [WINDOW];
   logic [TICK_W-1:0] r_in [WINDOW];
   logic              swap;

   always_comb begin
      swap = (r_ff[0] < r_ff[1]);
      for (int i = 0; i < WINDOW; i++) begin
         r_in[i] = r_ff[i];
      end
      if (shift_en) begin
         for (int i = 0; i < WINDOW - 1; i++) begin
            r_in[i] = r_ff[i + 1];
         end
         r_in[WINDOW-1] = shift_data;
      end else begin
         case (ctrl.op)
            OP_CMP: begin
               // larger value rides along in slot 0, smaller drops to the tail
               for (int i = 0; i < WINDOW - 1; i++) begin
                  r_in[i] = r_ff[i + 1];
               end
               r_in[0]        = swap ? r_ff[1] : r_ff[0];
               r_in[WINDOW-1] = swap ? r_ff[0] : r_ff[1];
            end
            OP_ROT, OP_SUM: begin
               for (int i = 0; i < WINDOW - 1; i++) begin
                  r_in[i] = r_ff[i + 1];
               end
               r_in[WINDOW-1] = r_ff[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW; i++) begin
         r_ff[i] <= r_in[i];
      end
   end

   assign head = r_ff[0];

endmodule

>>> rtl/core/edtm_arith.sv
// shared multiplier, accumulator and serial divider of the filter
`timescale 1ns / 1ps
module edtm_arith (
   input  logic                         clock,
   input  edtm_pkg::ctrl_type           ctrl,
   input  logic [edtm_pkg::CH_W-1:0]    req_channel,
   input  logic [edtm_pkg::TICK_W-1:0]  req_timer_count,
   input  logic [edtm_pkg::OVF_W-1:0]   req_overflow_count,
   input  logic [edtm_pkg::CFG_W-1:0]   ticks_per_overflow,
   input  logic [edtm_pkg::CFG_W-1:0]   cm_per_tick_q16,
   input  logic [edtm_pkg::TICK_W-1:0]  head,
   output logic [edtm_pkg::CH_W-1:0]    channel,
   output logic [edtm_pkg::TICK_W-1:0]  ticks,
   output logic                         ticks_sat,
   output logic [edtm_pkg::DIST_W-1:0]  raw_dist,
   output logic [edtm_pkg::DIST_W-1:0]  filt_dist,
   output logic                         in_range
);
   import edtm_pkg::*;

   logic [CH_W-1:0]   ch_ff;
   logic [TICK_W-1:0] count_ff;
   logic [OVF_W-1:0]  ovf_ff;
   logic [TICK_W-1:0] ticks_ff;
   logic              sat_ff;
   logic [DIST_W-1:0] raw_ff;
   logic [SUM_W-1:0]  acc_ff;
   logic [QUO_W-1:0]  dvd_ff;
   logic [REM_W-1:0]  rem_ff;

   logic [SUM_W-1:0]  mult_a;
   logic [CFG_W-1:0]  mult_b;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] tick_sum;
   logic              tick_over;
   logic              kept;
   logic [REM_W:0]    trial;
   logic              trial_ge;
   logic [REM_W-1:0]  rem_in;
   logic [QUO_W-1:0]  quo;

   always_comb begin
      case (ctrl.op)
         OP_TICKS: begin
            mult_a = SUM_W'(ovf_ff);
            mult_b = ticks_per_overflow;
         end
         OP_RAW: begin
            mult_a = SUM_W'(ticks_ff);
            mult_b = cm_per_tick_q16;
         end
         default: begin
            mult_a = acc_ff;
            mult_b = cm_per_tick_q16;
         end
      endcase
      prod      = {{CFG_W{1'b0}}, mult_a} * {{SUM_W{1'b0}}, mult_b};
      tick_sum  = prod + PROD_W'(count_ff);
      tick_over = |tick_sum[PROD_W-1:TICK_W];
      kept      = (int'(ctrl.cnt) >= START) && (int'(ctrl.cnt) < START + KEPT);
      // restoring division by the kept count, one quotient bit a cycle
      trial     = {rem_ff, dvd_ff[QUO_W-1]};
      trial_ge  = (trial >= (REM_W + 1)'(KEPT));
      rem_in    = trial_ge ? REM_W'(trial - (REM_W + 1)'(KEPT)) : REM_W'(trial);
      quo       = KEPT_POW2 ? (dvd_ff >> KEPT_LOG) : dvd_ff;
   end

   always_ff @(posedge clock) begin
      case (ctrl.op)
         OP_CAPTURE: begin
            ch_ff    <= req_channel;
            count_ff <= req_timer_count;
            ovf_ff   <= req_overflow_count;
         end
         OP_TICKS: begin
            ticks_ff <= tick_over ? TICK_MAX : tick_sum[TICK_W-1:0];
            sat_ff   <= tick_over;
         end
         OP_RAW: begin
            raw_ff <= sat_dist(prod[PROD_W-1:FRAC_W]);
            acc_ff <= '0;
         end
         OP_SUM: begin
            if (kept) begin
               acc_ff <= acc_ff + SUM_W'(head);
            end
         end
         OP_MEAN: begin
            dvd_ff <= prod[PROD_W-1:FRAC_W];
            rem_ff <= '0;
         end
         OP_DIV: begin
            if (!KEPT_POW2) begin
               rem_ff <= rem_in;
               dvd_ff <= {dvd_ff[QUO_W-2:0], trial_ge};
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      channel   = ch_ff;
      ticks     = ticks_ff;
      ticks_sat = sat_ff;
      raw_dist  = raw_ff;
      in_range  = (int'(ch_ff) < CHANNELS);
      filt_dist = in_range ? sat_dist(quo) : '0;
   end

endmodule

>>> rtl/core/edtm_ctrl.sv
// sequencer that steps one echo through the shared units
`timescale 1ns / 1ps
module edtm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                in_range,
   input  logic                out_free,
   output edtm_pkg::ctrl_type  ctrl,
   output logic                req_stall,
   output logic                out_load
);
   import edtm_pkg::*;

   state_type         state_ff;
   state_type         state_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic [PASS_W-1:0] pass_ff;
   logic [PASS_W-1:0] pass_in;
   logic              last_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pass_ff  <= pass_in;
      end
   end

   always_comb begin
      last_step = (cnt_ff == CNT_W'(WINDOW - 1));
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pass_in   = pass_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in  = '0;
            pass_in = '0;
            if (req_valid) begin
               state_in = ST_TICKS;
            end
         end
         ST_TICKS: begin
            state_in = ST_RAW;
         end
         ST_RAW: begin
            state_in = in_range ? ST_LOAD : ST_DONE;
         end
         ST_LOAD: begin
            if (cnt_ff == CNT_W'(WINDOW)) begin
               state_in = ST_SORT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_SORT: begin
            if (last_step) begin
               cnt_in = '0;
               if (pass_ff == PASS_W'(WINDOW - 2)) begin
                  state_in = ST_SUM;
               end else begin
                  pass_in = pass_ff + PASS_W'(1);
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_SUM: begin
            if (last_step) begin
               state_in = ST_MEAN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_MEAN: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (KEPT_POW2 || (cnt_ff == CNT_W'(QUO_W - 1))) begin
               state_in = ST_DONE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl.cnt  = cnt_ff;
      req_stall = (state_ff != ST_IDLE);
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE:  ctrl.op = req_valid ? OP_CAPTURE : OP_NONE;
         ST_TICKS: ctrl.op = OP_TICKS;
         ST_RAW:   ctrl.op = OP_RAW;
         ST_LOAD:  ctrl.op = OP_LOAD;
         ST_SORT:  ctrl.op = last_step ? OP_ROT : OP_CMP;
         ST_SUM:   ctrl.op = OP_SUM;
         ST_MEAN:  ctrl.op = OP_MEAN;
         ST_DIV:   ctrl.op = OP_DIV;
         ST_DONE: begin
            ctrl.op  = OP_NONE;
            out_load = out_free;
         end
         default:  ctrl.op = OP_NONE;
      endcase
   end

endmodule

>>> rtl/core/echo_distance_trimmed_mean_filter_core.sv
// top level of the echo distance trimmed mean filter
`timescale 1ns / 1ps
`include "assert_macros.svh"
// each transaction on req is one finished ultrasonic echo of a channel; the core turns
// timer_count + overflow_count * ticks_per_overflow into echo ticks (clamped to 65535,
// flagged in ticks_saturated), reports the raw distance in cm q8, shifts the ticks into
// that channel's window of WINDOW entries (zero after reset) and returns the mean of the
// KEPT middle entries of the sorted window, all as one rsp transaction. one echo is
// handled at a time and req is stalled meanwhile: an accept step, ticks and raw distance
// on the shared multiplier, window reload from memory, a rotating compare-swap sort, the
// kept sum, mean multiply, divide (a shift for a power-of-two kept count, else one
// quotient bit per cycle) and handoff; the time is bounded by the single compare-swap
// of the sort. an echo on a channel beyond CHANNELS skips the window steps and gives
// filtered distance zero. the rsp register lets the next echo start while the previous
// result waits. csr writes are expected only while idle
module echo_distance_trimmed_mean_filter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // echo input
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [edtm_pkg::CH_W-1:0]            req_channel,
   input  logic [edtm_pkg::TICK_W-1:0]          req_timer_count,
   input  logic [edtm_pkg::OVF_W-1:0]           req_overflow_count,
   // distance output
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [edtm_pkg::CH_W-1:0]            rsp_result_channel,
   output logic [edtm_pkg::DIST_W-1:0]          rsp_raw_distance_q8,
   output logic [edtm_pkg::DIST_W-1:0]          rsp_filtered_distance_q8,
   output logic                                 rsp_ticks_saturated,
   // register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [edtm_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [edtm_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [edtm_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);
   import edtm_pkg::*;

   // configuration registers
   logic [CFG_W-1:0]  tpo_ff;
   logic [CFG_W-1:0]  cm_ff;
   logic              csr_wr;
   csr_idx_type       csr_idx;

   // output register
   logic              rsp_valid_ff;
   logic [CH_W-1:0]   rsp_ch_ff;
   logic [DIST_W-1:0] rsp_raw_ff;
   logic [DIST_W-1:0] rsp_filt_ff;
   logic              rsp_sat_ff;

   // internal connections
   ctrl_type          ctrl;
   logic              out_load;
   logic              out_free;
   logic              in_range;
   logic [CH_W-1:0]   channel;
   logic [TICK_W-1:0] ticks;
   logic              ticks_sat;
   logic [DIST_W-1:0] raw_dist;
   logic [DIST_W-1:0] filt_dist;
   logic [TICK_W-1:0] head;
   logic              shift_en;
   logic [TICK_W-1:0] shift_data;

   // register access: index is the word address, upper data bits ignored
   always_comb begin
      pready  = 1'b1;
      csr_wr  = psel && penable && pwrite && pready;
      csr_idx = csr_idx_type'(paddr[2]);
      case (csr_idx)
         CSR_TPO: prdata = CSR_DATA_W'(tpo_ff);
         CSR_CM:  prdata = CSR_DATA_W'(cm_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpo_ff <= TPO_RESET;
         cm_ff  <= CM_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_TPO: tpo_ff <= pwdata[CFG_W-1:0];
            CSR_CM:  cm_ff  <= pwdata[CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   edtm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .in_range  (in_range),
      .out_free  (out_free),
      .ctrl      (ctrl),
      .req_stall (req_stall),
      .out_load  (out_load)
   );

   // shared multiplier, kept sum and divider
   edtm_arith u_arith (
      .clock              (clock),
      .ctrl               (ctrl),
      .req_channel        (req_channel),
      .req_timer_count    (req_timer_count),
      .req_overflow_count (req_overflow_count),
      .ticks_per_overflow (tpo_ff),
      .cm_per_tick_q16    (cm_ff),
      .head               (head),
      .channel            (channel),
      .ticks              (ticks),
      .ticks_sat          (ticks_sat),
      .raw_dist           (raw_dist),
      .filt_dist          (filt_dist),
      .in_range           (in_range)
   );

   // window store, shifted by one entry per echo
   edtm_win_mem u_win_mem (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .channel    (channel),
      .ticks      (ticks),
      .shift_en   (shift_en),
      .shift_data (shift_data)
   );

   // working copy of the window, sorted in place
   edtm_sort_regs u_sort_regs (
      .clock      (clock),
      .ctrl       (ctrl),
      .shift_en   (shift_en),
      .shift_data (shift_data),
      .head       (head)
   );

   // result register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ch_ff   <= channel;
         rsp_raw_ff  <= raw_dist;
         rsp_filt_ff <= filt_dist;
         rsp_sat_ff  <= ticks_sat;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_result_channel       = rsp_ch_ff;
   assign rsp_raw_distance_q8      = rsp_raw_ff;
   assign rsp_filtered_distance_q8 = rsp_filt_ff;
   assign rsp_ticks_saturated      = rsp_sat_ff;

   // an accepted echo keeps the input stalled until its result is handed off
   `EDTM_ASSERT_CLK(a_busy_after_accept, (req_valid && !req_stall) |=> req_stall, "input not stalled after accept")
   // a new result only appears from the sequencer handoff
   `EDTM_ASSERT_CLK(a_rsp_from_load, $rose(rsp_valid_ff) |-> $past(out_load), "result without handoff")
   // after handoff the core is idle and holds the result
   `EDTM_ASSERT_CLK(a_idle_after_load, out_load |=> (rsp_valid_ff && !req_stall), "handoff did not complete")

endmodule

>>> test/echo_distance_trimmed_mean_filter_core_tb.sv
// self-checking testbench of the echo distance trimmed mean filter core
`timescale 1ns / 1ps
module echo_distance_trimmed_mean_filter_core_tb;
   import edtm_pkg::*;

   // kept run of the sorted window, worked out here from the window parameters
   localparam int KEEP_N         = (KEPT_COUNT < WINDOW) ? KEPT_COUNT : WINDOW;
   localparam int KEEP_FIRST_RAW = WINDOW / 2 - CENTER_OFFSET;
   localparam int KEEP_FIRST     = (KEEP_FIRST_RAW < 0) ? 0 :
                                   ((KEEP_FIRST_RAW > WINDOW - KEEP_N) ? WINDOW - KEEP_N :
                                    KEEP_FIRST_RAW);
   localparam logic [DIST_W-1:0] DIST_TOP = {DIST_W{1'b1}};
   localparam int TICK_TOP = (1 << TICK_W) - 1;

   // run length: random phases, each opened by a register update
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 205;
   localparam int ITEM_CYCLES = WINDOW * WINDOW + WINDOW + 7;
   localparam int GAP_MAX     = 120;
   localparam int STALL_MAX   = 40;
   localparam int TAIL_CYCLES = 2 * ITEM_CYCLES;
   localparam int LIMIT       = 4 * (PHASES * PHASE_ITEMS + 30) *
                                (ITEM_CYCLES + GAP_MAX + STALL_MAX + 8);

   typedef struct packed {
      logic [CH_W-1:0]   channel;
      logic [DIST_W-1:0] raw_q8;
      logic [DIST_W-1:0] filt_q8;
      logic              sat;
   } distance_type;

   typedef enum logic {
      ROW_ECHO,
      ROW_CSR
   } row_kind_type;

   // one line of the directed table: an echo, or a register update between echoes
   typedef struct {
      row_kind_type      kind;
      csr_idx_type       idx;
      logic [CFG_W-1:0]  value;
      logic [CH_W-1:0]   ch;
      logic [TICK_W-1:0] cnt;
      logic [OVF_W-1:0]  ovf;
      bit                known;
      distance_type      gold;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid          = 1'b0;
   logic                  req_stall;
   logic [CH_W-1:0]       req_channel        = '0;
   logic [TICK_W-1:0]     req_timer_count    = '0;
   logic [OVF_W-1:0]      req_overflow_count = '0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CH_W-1:0]       rsp_result_channel;
   logic [DIST_W-1:0]     rsp_raw_distance_q8;
   logic [DIST_W-1:0]     rsp_filtered_distance_q8;
   logic                  rsp_ticks_saturated;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // predictor state: per-channel tick history and the two registers
   logic [TICK_W-1:0] hist_ticks [CHANNELS][WINDOW];
   logic [CFG_W-1:0]  tpo_model;
   logic [CFG_W-1:0]  scale_model;

   distance_type pending_distances [$];
   stim_row_type directed_rows [$];
   int           mismatches = 0;
   int           cycle_count = 0;
   int           stall_left = 0;
   int           stall_pick;

   echo_distance_trimmed_mean_filter_core dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_channel              (req_channel),
      .req_timer_count          (req_timer_count),
      .req_overflow_count       (req_overflow_count),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_result_channel       (rsp_result_channel),
      .rsp_raw_distance_q8      (rsp_raw_distance_q8),
      .rsp_filtered_distance_q8 (rsp_filtered_distance_q8),
      .rsp_ticks_saturated      (rsp_ticks_saturated),
      .psel                     (psel),
      .penable                  (penable),
      .pwrite                   (pwrite),
      .paddr                    (paddr),
      .pwdata                   (pwdata),
      .prdata                   (prdata),
      .pready                   (pready)
   );

   always #10 clock = ~clock;

   // distances clamp at the top of the 19 bit q8 range
   function automatic logic [DIST_W-1:0] clamp_q8(input logic [63:0] v);
      return (v > 64'(DIST_TOP)) ? DIST_TOP : v[DIST_W-1:0];
   endfunction

   // expected result of one echo; shifts the ticks into the channel history
   function automatic distance_type filter_echo(input logic [CH_W-1:0] ch,
                                                input logic [TICK_W-1:0] cnt,
                                                input logic [OVF_W-1:0] ovf);
      logic [31:0]       tick_sum;
      logic [TICK_W-1:0] ticks;
      logic [TICK_W-1:0] sorted [WINDOW];
      logic [TICK_W-1:0] swap;
      logic [63:0]       kept_sum;
      distance_type      res;
      tick_sum    = 32'(cnt) + 32'(ovf) * 32'(tpo_model);
      res.channel = ch;
      res.sat     = (tick_sum > 32'(TICK_TOP));
      ticks       = res.sat ? TICK_W'(TICK_TOP) : tick_sum[TICK_W-1:0];
      res.raw_q8  = clamp_q8((64'(ticks) * 64'(scale_model)) >> FRAC_W);
      res.filt_q8 = '0;
      if (int'(ch) < CHANNELS) begin
         for (int i = 0; i < WINDOW - 1; i++) begin
            hist_ticks[ch][i] = hist_ticks[ch][i+1];
         end
         hist_ticks[ch][WINDOW-1] = ticks;
         for (int i = 0; i < WINDOW; i++) begin
            sorted[i] = hist_ticks[ch][i];
         end
         for (int i = 0; i < WINDOW - 1; i++) begin
            for (int j = 0; j < WINDOW - 1 - i; j++) begin
               if (sorted[j] > sorted[j+1]) begin
                  swap        = sorted[j];
                  sorted[j]   = sorted[j+1];
                  sorted[j+1] = swap;
               end
            end
         end
         kept_sum = '0;
         for (int m = 0; m < KEEP_N; m++) begin
            kept_sum += 64'(sorted[KEEP_FIRST + m]);
         end
         res.filt_q8 = clamp_q8((kept_sum * 64'(scale_model)) / 64'(256 * KEEP_N));
      end
      return res;
   endfunction

   function automatic void add_echo(input logic [CH_W-1:0] ch, input logic [TICK_W-1:0] cnt,
                                    input logic [OVF_W-1:0] ovf);
      stim_row_type row;
      row       = '{kind: ROW_ECHO, idx: CSR_TPO, value: '0, ch: ch, cnt: cnt, ovf: ovf,
                    known: 1'b0, gold: '0};
      directed_rows.push_back(row);
   endfunction

   // echo whose result is obvious, typed in by hand
   function automatic void add_known(input logic [CH_W-1:0] ch, input logic [TICK_W-1:0] cnt,
                                     input logic [OVF_W-1:0] ovf, input logic [DIST_W-1:0] raw,
                                     input logic [DIST_W-1:0] filt, input logic sat);
      stim_row_type row;
      row = '{kind: ROW_ECHO, idx: CSR_TPO, value: '0, ch: ch, cnt: cnt, ovf: ovf,
              known: 1'b1, gold: '{channel: ch, raw_q8: raw, filt_q8: filt, sat: sat}};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_csr(input csr_idx_type idx, input logic [CFG_W-1:0] value);
      stim_row_type row;
      row = '{kind: ROW_CSR, idx: idx, value: value, ch: '0, cnt: '0, ovf: '0,
              known: 1'b0, gold: '0};
      directed_rows.push_back(row);
   endfunction

   // one apb transfer: setup, access until pready, then a return to idle
   task automatic csr_cycle(input bit is_write, input csr_idx_type idx,
                            input logic [CSR_DATA_W-1:0] wdata,
                            output logic [CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= CSR_ADDR_W'(4 * int'(idx));
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // write a register, mirror it in the predictor and read it back
   task automatic program_register(input csr_idx_type idx, input logic [CFG_W-1:0] value);
      logic [CSR_DATA_W-1:0] rd;
      csr_cycle(1'b1, idx, CSR_DATA_W'(value), rd);
      case (idx)
         CSR_TPO: tpo_model = value;
         CSR_CM:  scale_model = value;
         default: begin
         end
      endcase
      csr_cycle(1'b0, idx, '0, rd);
      if (rd !== CSR_DATA_W'(value)) begin
         $error("%s readback: expected %0d, actual %0d", idx.name(), value, rd);
         mismatches++;
      end
   endtask

   // present one echo and hold it until the core takes it; the expectation is queued
   // at the accepting edge, so it always precedes the matching result
   task automatic send_echo(input logic [CH_W-1:0] ch, input logic [TICK_W-1:0] cnt,
                            input logic [OVF_W-1:0] ovf, input bit known,
                            input distance_type gold);
      distance_type predicted;
      req_valid          <= 1'b1;
      req_channel        <= ch;
      req_timer_count    <= cnt;
      req_overflow_count <= ovf;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = filter_echo(ch, cnt, ovf);
      pending_distances.push_back(known ? gold : predicted);
   endtask

   // sender idle time after a transaction: mostly none or short, sometimes longer than
   // the core's own processing so the core also sees gaps while it is idle
   task automatic sender_gap(input bit no_idle);
      int r;
      int gap;
      r = $urandom_range(0, 99);
      if (no_idle || r < 40) begin
         gap = 0;
      end else if (r < 85) begin
         gap = $urandom_range(1, 4);
      end else if (r < 97) begin
         gap = $urandom_range(5, 90);
      end else begin
         gap = $urandom_range(91, GAP_MAX);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid and hold off until every outstanding result has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_distances.size() != 0);
   endtask

   // receiver back-pressure: free-flowing runs, short and long stalls, quiet stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 45) begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 10);
         end else if (stall_pick < 88) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 3);
         end else if (stall_pick < 96) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(4, STALL_MAX);
         end else begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(100, 400);
         end
      end
   end

   // result checker: every accepted result against the oldest expectation
   always @(posedge clock) begin
      distance_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_distances.size() == 0) begin
            $error("unexpected result transaction on channel %0d", rsp_result_channel);
            mismatches++;
         end else begin
            want = pending_distances.pop_front();
            if (rsp_result_channel !== want.channel) begin
               $error("result_channel: expected %0d, actual %0d", want.channel,
                      rsp_result_channel);
               mismatches++;
            end
            if (rsp_raw_distance_q8 !== want.raw_q8) begin
               $error("raw_distance_q8: expected %0d, actual %0d", want.raw_q8,
                      rsp_raw_distance_q8);
               mismatches++;
            end
            if (rsp_filtered_distance_q8 !== want.filt_q8) begin
               $error("filtered_distance_q8: expected %0d, actual %0d", want.filt_q8,
                      rsp_filtered_distance_q8);
               mismatches++;
            end
            if (rsp_ticks_saturated !== want.sat) begin
               $error("ticks_saturated: expected %0d, actual %0d", want.sat,
                      rsp_ticks_saturated);
               mismatches++;
            end
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int          want_ticks;
      int          cnt_i;
      int          ovf_i;
      int          r;
      int          track [1 << CH_W];
      logic [CH_W-1:0]  ch;
      logic [CFG_W-1:0] tpo_v;
      logic [CFG_W-1:0] cm_v;
      bit           no_idle;
      distance_type blank;

      blank = '0;
      foreach (hist_ticks[c, w]) begin
         hist_ticks[c][w] = '0;
      end
      tpo_model   = TPO_RESET;
      scale_model = CM_RESET;
      foreach (track[c]) begin
         track[c] = $urandom_range(500, 30000);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table; reset registers first: 399 ticks per overflow, 1114 q16
      // empty windows: zero echo, full-scale count alone, and two saturating sums
      add_known(2'd0, 16'd0, 8'd0, 19'd0, 19'd0, 1'b0);
      add_known(2'd1, 16'hFFFF, 8'd0, 19'd285179, 19'd0, 1'b0);
      add_known(2'd2, 16'hFFFF, 8'hFF, 19'd285179, 19'd0, 1'b1);
      add_known(2'd3, 16'd0, 8'hFF, 19'd285179, 19'd0, 1'b1);
      // tick sum exactly at the clamp point, then one above it
      add_echo(2'd3, 16'd99, 8'd164);
      add_echo(2'd3, 16'd100, 8'd164);
      // fill channel 0 past its window depth, with outliers that the trim drops
      add_echo(2'd0, 16'd1000, 8'd0);
      add_echo(2'd0, 16'd1200, 8'd0);
      add_echo(2'd0, 16'd0, 8'd2);
      add_echo(2'd0, 16'd50000, 8'd0);
      add_echo(2'd0, 16'd1100, 8'd0);
      add_echo(2'd0, 16'hFFFF, 8'hFF);
      add_echo(2'd0, 16'd1050, 8'd1);
      add_echo(2'd0, 16'd980, 8'd0);
      // largest scale: the distance itself saturates
      add_csr(CSR_TPO, 16'hFFFF);
      add_csr(CSR_CM, 16'hFFFF);
      add_known(2'd1, 16'hFFFF, 8'd0, DIST_TOP, 19'd0, 1'b0);
      add_echo(2'd2, 16'd0, 8'd1);
      add_echo(2'd2, 16'd1, 8'd1);
      // smallest overflow period with zero scale: all distances vanish
      add_csr(CSR_TPO, 16'd1);
      add_csr(CSR_CM, 16'd0);
      add_known(2'd0, 16'hFFFF, 8'hFF, 19'd0, 19'd0, 1'b1);
      add_known(2'd1, 16'd12345, 8'd200, 19'd0, 19'd0, 1'b0);
      add_csr(CSR_CM, 16'd1);
      add_echo(2'd3, 16'hFFFF, 8'd0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_drain();
            program_register(directed_rows[i].idx, directed_rows[i].value);
         end else begin
            send_echo(directed_rows[i].ch, directed_rows[i].cnt, directed_rows[i].ovf,
                      directed_rows[i].known, directed_rows[i].gold);
            sender_gap(1'b0);
         end
      end

      // random phases; each starts from an idle core with a fresh register setting
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               tpo_v = TPO_RESET;
               cm_v  = CM_RESET;
            end
            1: begin
               tpo_v = 16'hFFFF;
               cm_v  = 16'hFFFF;
            end
            2: begin
               tpo_v = 16'd1;
               cm_v  = 16'd1;
            end
            3: begin
               tpo_v = 16'd1;
               cm_v  = 16'd0;
            end
            default: begin
               tpo_v = CFG_W'($urandom_range(1, 65535));
               cm_v  = CFG_W'($urandom_range(0, 65535));
            end
         endcase
         wait_drain();
         program_register(CSR_TPO, tpo_v);
         program_register(CSR_CM, cm_v);
         foreach (track[c]) begin
            track[c] = ($urandom_range(0, 4) == 0) ? $urandom_range(60000, 70000) :
                                                      $urandom_range(0, 40000);
         end

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // now and then a run of back-to-back transactions
            if (n % 32 == 0) begin
               no_idle = ($urandom_range(0, 3) == 0);
            end
            ch = CH_W'($urandom_range(0, (1 << CH_W) - 1));
            if ($urandom_range(0, 199) == 0) begin
               track[ch] = $urandom_range(0, 70000);
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
               // a steady target with jitter and the odd outlier, split the way a timer
               // splits it: whole overflow periods plus the remainder
               want_ticks = track[ch] + $urandom_range(0, 128) - 64;
               if ($urandom_range(0, 15) == 0) begin
                  want_ticks = $urandom_range(0, 70000);
               end
               if (want_ticks < 0) begin
                  want_ticks = 0;
               end
               ovf_i = want_ticks / int'(tpo_model);
               if (ovf_i > 255) begin
                  ovf_i = 255;
               end
               cnt_i = want_ticks - ovf_i * int'(tpo_model);
            end else if (r < 85) begin
               cnt_i = $urandom_range(0, 65535);
               ovf_i = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) :
                                                     $urandom_range(0, 255);
            end else begin
               // field extremes and the clamp boundary
               case ($urandom_range(0, 2))
                  0:       cnt_i = 0;
                  1:       cnt_i = 65535;
                  default: cnt_i = $urandom_range(0, 65535);
               endcase
               case ($urandom_range(0, 3))
                  0: ovf_i = 0;
                  1: ovf_i = 255;
                  2: begin
                     ovf_i = TICK_TOP / int'(tpo_model);
                     if (ovf_i > 255) begin
                        ovf_i = 255;
                     end
                     cnt_i = TICK_TOP - ovf_i * int'(tpo_model) + $urandom_range(0, 1);
                  end
                  default: ovf_i = $urandom_range(0, 255);
               endcase
            end
            if (cnt_i > TICK_TOP) begin
               cnt_i = TICK_TOP;
            end
            send_echo(ch, cnt_i[TICK_W-1:0], ovf_i[OVF_W-1:0], 1'b0, blank);
            sender_gap(no_idle);
            // occasionally let the pipeline run completely dry
            if ($urandom_range(0, 99) == 0) begin
               wait_drain();
            end
         end
      end

      // drain, then watch a while longer for stray results
      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
